[hdl/pct_pkg.sv]
package pct_pkg;

  localparam int FRAC_BITS  = 10;
  localparam int CHAN_W     = 8;
  localparam int KEEP_W     = FRAC_BITS;
  localparam int KEEP_REG_W = 3 * FRAC_BITS;
  localparam int PROD_W     = CHAN_W + KEEP_W;
  localparam int CFG_IDX_W  = 2;
  localparam int NUM_CHAN   = 3;
  localparam int SUM_W      = CHAN_W + 2;

  localparam logic [CHAN_W-1:0] CHAN_MAX = '1;
  localparam logic [KEEP_W-1:0] KEEP_ONE_LSB_MASK = '1;

  localparam logic [CHAN_W-1:0]     SPLIT_RESET  = CHAN_W'(100);
  localparam logic [KEEP_REG_W-1:0] BRIGHT_RESET = KEEP_REG_W'(64'd752143667);
  localparam logic [KEEP_REG_W-1:0] DARK_RESET   = KEEP_REG_W'(64'd967732122);
  localparam logic [KEEP_REG_W-1:0] DIM_RESET    = KEEP_REG_W'(64'd322752307);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPLIT  = 2'd0,
    REG_BRIGHT = 2'd1,
    REG_DARK   = 2'd2,
    REG_DIM    = 2'd3
  } cfg_reg_t;

  // Stage enables handed to each channel lane
  typedef struct packed {
    logic en_mul;
    logic en_out;
  } lane_ctl_t;

  function automatic logic [KEEP_W-1:0] keep_of(input logic [KEEP_REG_W-1:0] packed_keep,
                                                input int ch);
    return packed_keep[ch*KEEP_W +: KEEP_W];
  endfunction

endpackage

[hdl/pct_lane.sv]
module pct_lane (
  input  logic                      clk,
  input  pct_pkg::lane_ctl_t        ctl,
  input  logic [pct_pkg::CHAN_W-1:0] d,
  input  logic [pct_pkg::CHAN_W-1:0] base,
  input  logic                      sub,
  input  logic [pct_pkg::KEEP_W-1:0] k,
  output logic [pct_pkg::CHAN_W-1:0] res
);
  import pct_pkg::*;

  logic [PROD_W-1:0] prod;
  logic [CHAN_W-1:0] base2;
  logic              sub2;

  logic [PROD_W:0]        prod_up;
  logic [CHAN_W:0]        mag_up;
  logic [CHAN_W:0]        mag_down;
  logic [CHAN_W:0]        res_next;

  always_ff @(posedge clk) begin
    if (ctl.en_mul) begin
      prod  <= PROD_W'(d) * PROD_W'(k);
      base2 <= base;
      sub2  <= sub;
    end
  end

  // Subtracting paths take the product rounded up, adding paths rounded down
  always_comb begin
    prod_up  = (PROD_W+1)'(prod) + (PROD_W+1)'(KEEP_ONE_LSB_MASK);
    mag_up   = prod_up[PROD_W:FRAC_BITS];
    mag_down = (CHAN_W+1)'(prod[PROD_W-1:FRAC_BITS]);
    if (sub2) begin
      res_next = (CHAN_W+1)'(base2) - mag_up;
    end else begin
      res_next = (CHAN_W+1)'(base2) + mag_down;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en_out) begin
      res <= res_next[CHAN_W-1:0];
    end
  end

endmodule

[hdl/palette_contrast_tint_core.sv]
// Channel  Handshake              Payload
// in       in_valid / in_stall    red_in, green_in, blue_in, highlight
// out      out_valid / out_stall  red_out, green_out, blue_out
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Three register stages: operand select (mean test, pivot compare), 8x10 multiply
// per channel, round and add/subtract into the output register. One word per
// cycle sustained while out_stall is low. Stalls hold every occupied stage,
// empty stages still fill. Reset clears the valid bits and loads the
// default keep factors and split level; cfg_ready is always high.
module palette_contrast_tint_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pct_pkg::CHAN_W-1:0]    red_in,
  input  logic [pct_pkg::CHAN_W-1:0]    green_in,
  input  logic [pct_pkg::CHAN_W-1:0]    blue_in,
  input  logic                          highlight,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pct_pkg::CHAN_W-1:0]    red_out,
  output logic [pct_pkg::CHAN_W-1:0]    green_out,
  output logic [pct_pkg::CHAN_W-1:0]    blue_out,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pct_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pct_pkg::KEEP_REG_W-1:0] cfg_data
);
  import pct_pkg::*;

  logic [CHAN_W-1:0]     split_level;
  logic [KEEP_REG_W-1:0] bright_keep;
  logic [KEEP_REG_W-1:0] dark_keep;
  logic [KEEP_REG_W-1:0] dim_keep;

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;

  logic [CHAN_W-1:0] chan   [NUM_CHAN];
  logic [CHAN_W-1:0] d_next [NUM_CHAN];
  logic [CHAN_W-1:0] b_next [NUM_CHAN];
  logic              s_next [NUM_CHAN];
  logic [KEEP_W-1:0] k_next [NUM_CHAN];

  logic [CHAN_W-1:0] d1 [NUM_CHAN];
  logic [CHAN_W-1:0] b1 [NUM_CHAN];
  logic              s1 [NUM_CHAN];
  logic [KEEP_W-1:0] k1 [NUM_CHAN];

  logic [CHAN_W-1:0] res [NUM_CHAN];

  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] three_split;
  logic             bright;

  lane_ctl_t lane_ctl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      split_level <= SPLIT_RESET;
      bright_keep <= BRIGHT_RESET;
      dark_keep   <= DARK_RESET;
      dim_keep    <= DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_SPLIT:  split_level <= cfg_data[CHAN_W-1:0];
        REG_BRIGHT: bright_keep <= cfg_data;
        REG_DARK:   dark_keep   <= cfg_data;
        REG_DIM:    dim_keep    <= cfg_data;
        default:    ;
      endcase
    end
  end

  // A stage advances when it is empty or its successor moves on
  assign rdy3     = !v3 || !out_stall;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_stall = !rdy1;

  assign lane_ctl.en_mul = rdy2;
  assign lane_ctl.en_out = rdy3;

  assign chan[0] = red_in;
  assign chan[1] = green_in;
  assign chan[2] = blue_in;

  // floor(sum / 3) >= split is the same test as sum >= 3 * split
  always_comb begin
    logic [CHAN_W-1:0] x;
    logic              ge;
    sum         = SUM_W'(red_in) + SUM_W'(green_in) + SUM_W'(blue_in);
    three_split = SUM_W'({split_level, 1'b0}) + SUM_W'(split_level);
    bright      = sum >= three_split;
    x  = '0;
    ge = 1'b0;
    for (int i = 0; i < NUM_CHAN; i++) begin
      x  = chan[i];
      ge = x >= split_level;
      if (highlight) begin
        if (bright) begin
          b_next[i] = CHAN_MAX;
          d_next[i] = CHAN_MAX - x;
          s_next[i] = 1'b1;
          k_next[i] = keep_of(bright_keep, i);
        end else begin
          b_next[i] = '0;
          d_next[i] = x;
          s_next[i] = 1'b0;
          k_next[i] = keep_of(dark_keep, i);
        end
      end else if (i == NUM_CHAN - 1) begin
        // blue: pull toward full scale or scale down
        k_next[i] = keep_of(dim_keep, i);
        if (ge) begin
          b_next[i] = CHAN_MAX;
          d_next[i] = CHAN_MAX - x;
          s_next[i] = 1'b1;
        end else begin
          b_next[i] = '0;
          d_next[i] = x;
          s_next[i] = 1'b0;
        end
      end else begin
        // red, green: squeeze toward the split level
        k_next[i] = keep_of(dim_keep, i);
        b_next[i] = split_level;
        if (ge) begin
          d_next[i] = x - split_level;
          s_next[i] = 1'b0;
        end else begin
          d_next[i] = split_level - x;
          s_next[i] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= in_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      for (int i = 0; i < NUM_CHAN; i++) begin
        d1[i] <= d_next[i];
        b1[i] <= b_next[i];
        s1[i] <= s_next[i];
        k1[i] <= k_next[i];
      end
    end
  end

  for (genvar g = 0; g < NUM_CHAN; g++) begin : g_lane
    pct_lane u_lane (
      .clk  (clk),
      .ctl  (lane_ctl),
      .d    (d1[g]),
      .base (b1[g]),
      .sub  (s1[g]),
      .k    (k1[g]),
      .res  (res[g])
    );
  end

  assign out_valid = v3;
  assign red_out   = res[0];
  assign green_out = res[1];
  assign blue_out  = res[2];

`ifndef SYNTHESIS
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> v1)
    else $error("accepted word did not enter the first stage");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (v1 && v2 && v3 && out_stall) |-> in_stall)
    else $error("input taken while the pipeline is full and stalled");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    (v1 && rdy2) |=> v2)
    else $error("word lost between the first and second stage");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    (!v1 && !v2 && !v3) |-> !in_stall)
    else $error("empty pipeline stalls the input");
`endif

endmodule
